@@ src/sorted_table_insert_remove_top_defines.svh @@
// Assertion macros for the sorted table block.
// Included by the top level; no other dependencies.
`ifndef SORTED_TABLE_INSERT_REMOVE_TOP_DEFINES_SVH
`define SORTED_TABLE_INSERT_REMOVE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define STIR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define STIR_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/stir_pkg.sv @@
// Shared types and constants for the sorted table block.
// No dependencies.
`default_nettype none

package stir_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int GRP_MAX      = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_REMOVED   = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_READ_OK   = 3'd5,
        STAT_RANGE     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_INS  = 2'd1,
        CMD_DEL  = 2'd2
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EVAL  = 2'd1,
        ST_APPLY = 2'd2
    } state_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] entry;
        logic                      occ;
        logic                      le;
    } cell_link_t;

endpackage

`default_nettype wire

@@ src/sorted_table_insert_remove_top.sv @@
// Sorted table of signed values in a chain of shifting cells.
// A new request is taken only in the idle state; req_stall stays high while it is
// compared, reduced by the registered group stage across the cells, then shifted and
// answered, and the answer waits while res_stall holds the output.
// Reset: occupancy flags and count clear at once; no clearing pass.
// Depends on stir_pkg, stir_cell, stir_group and the defines header.
`default_nettype none
`include "sorted_table_insert_remove_top_defines.svh"

module sorted_table_insert_remove_top #(
    parameter  int CAPACITY = stir_pkg::CAPACITY_DEF,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire logic [1:0]                           req_type,
    input  wire logic signed [stir_pkg::VALUE_W-1:0]  value,
    input  wire logic [IDX_W-1:0]                     index,
    output logic                                      res_valid,
    input  wire logic                                 res_stall,
    output logic [2:0]                                status,
    output logic [CNT_W-1:0]                          count,
    output logic signed [stir_pkg::VALUE_W-1:0]       read_value
);
    import stir_pkg::*;

    localparam int GRP_N  = (CAPACITY > GRP_MAX) ? GRP_MAX : (1 << $clog2(CAPACITY));
    localparam int LOG_G  = $clog2(GRP_N);
    localparam int NG     = (CAPACITY + GRP_N - 1) / GRP_N;
    localparam int GSEL_W = (NG > 1) ? $clog2(NG) : 1;
    localparam int NGP    = 1 << GSEL_W;

    state_t                    state_reg;
    state_t                    state_next;
    logic [1:0]                req_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      res_valid_reg;
    status_t                   res_status_reg;
    logic [CNT_W-1:0]          res_count_reg;
    logic [VALUE_W-1:0]        res_value_reg;

    cell_cmd_t                 cmd_comb;
    cell_cmd_t                 cell_cmd;
    status_t                   stat_comb;
    logic [VALUE_W-1:0]        rv_comb;
    logic                      accept;
    logic                      out_free;
    logic                      apply_go;
    logic                      found;
    logic                      full;
    logic [GSEL_W-1:0]         gsel;

    cell_link_t                       links [CAPACITY];
    cell_link_t                       head_link;
    cell_link_t                       tail_link;
    logic [NGP*GRP_N-1:0]             eq_pad;
    logic [NGP*GRP_N-1:0][VALUE_W-1:0] ent_pad;
    logic [NGP-1:0]                   grp_hit;
    logic [NGP-1:0][VALUE_W-1:0]      grp_val;

    assign head_link = '{entry: '0, occ: 1'b0, le: 1'b1};
    assign tail_link = '{entry: '0, occ: 1'b0, le: 1'b0};

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_link_t lnk_l;
            cell_link_t lnk_r;
            if (i == 0)
            begin : g_head
                assign lnk_l = head_link;
            end
            else
            begin : g_mid_l
                assign lnk_l = links[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_tail
                assign lnk_r = tail_link;
            end
            else
            begin : g_mid_r
                assign lnk_r = links[i+1];
            end
            stir_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cell_cmd),
                .key   (key_reg),
                .left  (lnk_l),
                .right (lnk_r),
                .link  (links[i]),
                .eq    (eq_pad[i])
            );
            assign ent_pad[i] = links[i].entry;
        end
        for (i = CAPACITY; i < NGP * GRP_N; i++)
        begin : g_pad
            assign eq_pad[i]  = 1'b0;
            assign ent_pad[i] = '0;
        end
        for (i = 0; i < NGP; i++)
        begin : g_grp
            stir_group #(
                .GRP_N (GRP_N),
                .LOG_G (LOG_G)
            ) u_grp (
                .clk     (clk),
                .eq      (eq_pad[i*GRP_N +: GRP_N]),
                .entries (ent_pad[i*GRP_N +: GRP_N]),
                .sel     (idx_reg[LOG_G-1:0]),
                .hit     (grp_hit[i]),
                .val     (grp_val[i])
            );
        end
        if (NG > 1)
        begin : g_gsel
            assign gsel = idx_reg[IDX_W-1:LOG_G];
        end
        else
        begin : g_gsel_one
            assign gsel = '0;
        end
    endgenerate

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign out_free  = !res_valid_reg || !res_stall;
    assign apply_go  = (state_reg == ST_APPLY) && out_free;
    assign found     = |grp_hit;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign cell_cmd  = apply_go ? cmd_comb : CMD_HOLD;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_comb   = CMD_HOLD;
        stat_comb  = STAT_RANGE;
        rv_comb    = '0;
        count_next = count_reg;
        unique case (req_reg)
            REQ_INSERT:
            begin
                if (full)
                begin
                    stat_comb = STAT_FULL;
                end
                else
                begin
                    cmd_comb   = CMD_INS;
                    stat_comb  = STAT_INSERTED;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    stat_comb = STAT_EMPTY;
                end
                else if (found)
                begin
                    cmd_comb   = CMD_DEL;
                    stat_comb  = STAT_REMOVED;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    stat_comb = STAT_NOT_FOUND;
                end
            end
            REQ_READ:
            begin
                if (CNT_W'(idx_reg) < count_reg)
                begin
                    stat_comb = STAT_READ_OK;
                    rv_comb   = grp_val[gsel];
                end
            end
            default:
            begin
                stat_comb = STAT_RANGE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_go)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            key_reg <= value;
            idx_reg <= index;
        end
        if (apply_go)
        begin
            res_status_reg <= stat_comb;
            res_count_reg  <= count_next;
            res_value_reg  <= rv_comb;
        end
    end

    assign res_valid  = res_valid_reg;
    assign status     = res_status_reg;
    assign count      = res_count_reg;
    assign read_value = res_value_reg;

    `STIR_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "count above capacity")
    `STIR_ASSERT_NXT(a_accept_eval, clk, rst_n, accept, state_reg == ST_EVAL,
        "accept did not start compare")
    `STIR_ASSERT_NXT(a_ins_count, clk, rst_n, cell_cmd == CMD_INS,
        count_reg == $past(count_reg) + CNT_W'(1), "insert did not raise count")
    `STIR_ASSERT_IMP(a_head_occ, clk, rst_n, 1'b1, links[0].occ == (count_reg != '0),
        "head occupancy disagrees with count")

endmodule

`default_nettype wire

@@ src/stir_cell.sv @@
// One table slot: holds an entry and its occupancy, compares it to the key
// and shifts right on insert or left on remove. Depends on stir_pkg.
`default_nettype none

module stir_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire stir_pkg::cell_cmd_t             cmd,
    input  wire logic signed [stir_pkg::VALUE_W-1:0] key,
    input  wire stir_pkg::cell_link_t            left,
    input  wire stir_pkg::cell_link_t            right,
    output stir_pkg::cell_link_t                 link,
    output logic                                 eq
);
    import stir_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      occ_reg;
    logic                      occ_next;
    logic                      le;
    logic                      lt;

    assign le = occ_reg && (entry_reg <= key);
    assign lt = occ_reg && (entry_reg < key);
    assign eq = occ_reg && (entry_reg == key);

    assign link.entry = entry_reg;
    assign link.occ   = occ_reg;
    assign link.le    = le;

    always_comb
    begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        unique case (cmd)
            CMD_INS:
            begin
                if (!le)
                begin
                    if (left.le)
                    begin
                        entry_next = key;
                        occ_next   = 1'b1;
                    end
                    else
                    begin
                        entry_next = left.entry;
                        occ_next   = left.occ;
                    end
                end
            end
            CMD_DEL:
            begin
                if (!lt)
                begin
                    entry_next = right.entry;
                    occ_next   = right.occ;
                end
            end
            CMD_HOLD:
            begin
                entry_next = entry_reg;
                occ_next   = occ_reg;
            end
            default:
            begin
                entry_next = entry_reg;
                occ_next   = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ src/stir_group.sv @@
// Registered reduction over one group of cells: match flag and entry select.
// Depends on stir_pkg.
`default_nettype none

module stir_group #(
    parameter int GRP_N = 32,
    parameter int LOG_G = 5
) (
    input  wire logic                                    clk,
    input  wire logic [GRP_N-1:0]                        eq,
    input  wire logic [GRP_N-1:0][stir_pkg::VALUE_W-1:0] entries,
    input  wire logic [LOG_G-1:0]                        sel,
    output logic                                         hit,
    output logic [stir_pkg::VALUE_W-1:0]                 val
);
    import stir_pkg::*;

    logic                 hit_reg;
    logic [VALUE_W-1:0]   val_reg;

    always_ff @(posedge clk)
    begin
        hit_reg <= |eq;
        val_reg <= entries[sel];
    end

    assign hit = hit_reg;
    assign val = val_reg;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for sorted_table_insert_remove_top: insert, remove and read requests.
// Holds its own copy of the sorted table and checks every result against it.
// Depends on stir_pkg and the RTL under src.
`timescale 1ns / 100ps

module tb;
    import stir_pkg::*;

    localparam int SLOTS = CAPACITY_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [2:0]         status;
        logic [6:0]         count;
        logic signed [31:0] read_value;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [1:0]         req_type;
    logic signed [31:0] value;
    logic [5:0]         index;
    logic               res_valid;
    logic               res_stall;
    logic [2:0]         status;
    logic [6:0]         count;
    logic signed [31:0] read_value;

    int      held [SLOTS];
    int      held_count;
    answer_t answers_due [$];
    int      fails;
    int      burst_left;
    int      gap_max;
    int      stall_pct;
    int      hold_cycles;
    int      pool [12];

    sorted_table_insert_remove_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .value      (value),
        .index      (index),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .status     (status),
        .count      (count),
        .read_value (read_value)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic answer_t apply_request(logic [1:0] kind, logic signed [31:0] v,
                                              logic [5:0] i);
        answer_t r;
        int      p;
        r.read_value = '0;
        case (kind)
            REQ_INSERT:
            begin
                if (held_count >= SLOTS)
                    r.status = STAT_FULL;
                else
                begin
                    p = held_count;
                    while (p > 0 && held[p-1] > v)
                    begin
                        held[p] = held[p-1];
                        p--;
                    end
                    held[p] = v;
                    held_count++;
                    r.status = STAT_INSERTED;
                end
            end
            REQ_REMOVE:
            begin
                if (held_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    p = 0;
                    while (p < held_count && held[p] < v)
                        p++;
                    if (p < held_count && held[p] == v)
                    begin
                        for (int k = p; k < held_count - 1; k++)
                            held[k] = held[k+1];
                        held_count--;
                        r.status = STAT_REMOVED;
                    end
                    else
                        r.status = STAT_NOT_FOUND;
                end
            end
            REQ_READ:
            begin
                if (int'(i) < held_count)
                begin
                    r.status     = STAT_READ_OK;
                    r.read_value = held[i];
                end
                else
                    r.status = STAT_RANGE;
            end
            default:
                r.status = STAT_RANGE;
        endcase
        r.count = held_count[6:0];
        return r;
    endfunction

    function automatic void post_answer(input answer_t a);
        answers_due.insert(answers_due.size(), a);
    endfunction

    function automatic logic signed [31:0] choose_value();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return pool[$urandom_range(11)];
        if (r < 70 && held_count > 0)
            return held[$urandom_range(held_count - 1)];
        return $urandom;
    endfunction

    function automatic logic [5:0] choose_index();
        if (held_count > 0 && $urandom_range(99) < 80)
            return 6'($urandom_range(held_count - 1));
        return 6'($urandom_range(63));
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            req_type  = 2'($urandom);
            value     = $urandom;
            index     = 6'($urandom);
        end
    endtask

    task automatic send_request(input logic [1:0] kind, input logic signed [31:0] v,
                                input logic [5:0] i);
        if (burst_left == 0)
        begin
            if (gap_max > 0)
                idle_cycles($urandom_range(1, gap_max));
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        req_valid = 1'b1;
        req_type  = kind;
        value     = v;
        index     = i;
        do
            @(posedge clk);
        while (req_stall);
        post_answer(apply_request(kind, v, i));
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_stall = 1'b1;
            hold_cycles--;
        end
        else
            res_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        answer_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected result: status %0d count %0d", status, count);
                fails++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fails++;
                end
                if (count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, count);
                    fails++;
                end
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d", want.read_value, read_value);
                    fails++;
                end
            end
        end
    end

    task automatic test_empty_table();
        send_request(REQ_REMOVE, 32'sd5, 6'd0);
        send_request(REQ_READ, 32'sd0, 6'd0);
        send_request(REQ_READ, 32'sd0, 6'd63);
        send_request(REQ_UNUSED, -32'sd1, 6'd63);
        wait_drained();
    endtask

    task automatic test_extremes();
        send_request(REQ_INSERT, 32'sh8000_0000, 6'd0);
        send_request(REQ_INSERT, 32'sh7FFF_FFFF, 6'd0);
        send_request(REQ_INSERT, 32'sd0, 6'd0);
        send_request(REQ_INSERT, -32'sd1, 6'd0);
        send_request(REQ_INSERT, 32'sd0, 6'd0);
        for (int k = 0; k < 6; k++)
            send_request(REQ_READ, 32'sd0, k[5:0]);
        send_request(REQ_READ, 32'sd0, 6'd63);
        send_request(REQ_REMOVE, 32'sd7, 6'd0);
        send_request(REQ_REMOVE, 32'sd0, 6'd0);
        send_request(REQ_REMOVE, 32'sh8000_0000, 6'd0);
        send_request(REQ_REMOVE, 32'sh7FFF_FFFF, 6'd0);
        send_request(REQ_UNUSED, 32'sd0, 6'd0);
        send_request(REQ_READ, 32'sd0, 6'd0);
        wait_drained();
    endtask

    task automatic test_fill_and_empty();
        while (held_count < SLOTS)
            send_request(REQ_INSERT, choose_value(), 6'($urandom));
        send_request(REQ_INSERT, choose_value(), 6'($urandom));
        send_request(REQ_INSERT, 32'sh7FFF_FFFF, 6'($urandom));
        send_request(REQ_READ, 32'sd0, 6'd63);
        send_request(REQ_READ, 32'sd0, 6'd0);
        while (held_count > 0)
            send_request(REQ_REMOVE, held[$urandom_range(held_count - 1)], 6'($urandom));
        send_request(REQ_REMOVE, choose_value(), 6'($urandom));
        wait_drained();
    endtask

    task automatic test_backpressure();
        gap_max     = 0;
        hold_cycles = 80;
        repeat (30)
            send_request(REQ_INSERT, choose_value(), 6'($urandom));
        wait_drained();
    endtask

    task automatic test_random_mix();
        int r;
        int ins_cut;
        for (int round = 0; round < 4; round++)
        begin
            ins_cut   = (round % 2 == 0) ? 55 : 20;
            gap_max   = (round == 1) ? 0 : 2 + 3 * round;
            stall_pct = (round == 2) ? 0 : 20 * round + 10;
            repeat (90)
            begin
                r = $urandom_range(99);
                if (r < ins_cut)
                    send_request(REQ_INSERT, choose_value(), 6'($urandom));
                else if (r < 75)
                    send_request(REQ_REMOVE, choose_value(), 6'($urandom));
                else if (r < 97)
                    send_request(REQ_READ, $urandom, choose_index());
                else
                    send_request(REQ_UNUSED, $urandom, 6'($urandom));
            end
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_type    = REQ_INSERT;
        value       = '0;
        index       = '0;
        held_count  = 0;
        fails       = 0;
        burst_left  = 0;
        gap_max     = 4;
        stall_pct   = 25;
        hold_cycles = 0;
        pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 2, -2, 100, -100,
                 32'sh5555_5555, 32'shAAAA_AAAA, 42};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_extremes();
        test_fill_and_empty();
        test_backpressure();
        gap_max   = 4;
        stall_pct = 25;
        test_random_mix();

        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
